// ----- design/rdsc_pkg.sv -----
// Shared types, constants and helpers for the radix digit string converter.
package rdsc_pkg;

  localparam int unsigned ValueW    = 64;
  localparam int unsigned MaxDigits = 64;
  localparam int unsigned CntW      = 7;
  localparam int unsigned RadixW    = 6;
  localparam int unsigned DigitW    = 6;
  localparam int unsigned CharW     = 7;
  localparam int unsigned AddrW     = 3;

  localparam logic [RadixW-1:0] RadixMin   = RadixW'(2);
  localparam logic [RadixW-1:0] RadixMax   = RadixW'(36);
  localparam logic [RadixW-1:0] RadixReset = RadixW'(10);

  // Register index taken from paddr[2]
  localparam logic RegRadix = 1'b0;

  // Conversion window: ends once the last value bit has reached the top cell
  localparam logic [CntW-1:0] ConvLast = CntW'(ValueW + MaxDigits - 2);
  localparam logic [CntW-1:0] EmitLast = CntW'(MaxDigits - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic clr;    // zero digit and carry
    logic shift;  // move digits one cell toward the top
  } cell_ctrl_t;

  function automatic logic [CharW-1:0] digit_to_ascii(input logic [DigitW-1:0] d);
    logic [CharW-1:0] r;
    if (d > DigitW'(9)) begin
      r = CharW'(d) - CharW'(10) + CharW'(8'h61);
    end else begin
      r = CharW'(d) + CharW'(8'h30);
    end
    return r;
  endfunction

endpackage

// ----- design/rdsc_cell.sv -----
// One digit cell: doubles its digit plus an incoming carry, modulo the radix, or clears or shifts its digit.
module rdsc_cell (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  rdsc_pkg::cell_ctrl_t        ctrl_i,
  input  logic [rdsc_pkg::RadixW-1:0] radix_i,
  input  logic                        carry_i,
  input  logic                        valid_i,
  input  logic [rdsc_pkg::DigitW-1:0] digit_i,
  output logic                        carry_o,
  output logic                        valid_o,
  output logic [rdsc_pkg::DigitW-1:0] digit_o
);
  import rdsc_pkg::*;

  logic [DigitW-1:0] digit_q, digit_d;
  logic              carry_q, carry_d;
  logic              valid_q, valid_d;
  logic [DigitW:0]   dbl;
  logic              ge;

  always_comb begin
    dbl     = {digit_q, carry_i};
    ge      = dbl >= {1'b0, radix_i};
    digit_d = digit_q;
    carry_d = 1'b0;
    valid_d = 1'b0;
    if (ctrl_i.clr) begin
      digit_d = '0;
    end else if (ctrl_i.shift) begin
      digit_d = digit_i;
    end else if (valid_i) begin
      digit_d = ge ? DigitW'(dbl - {1'b0, radix_i}) : dbl[DigitW-1:0];
      carry_d = ge;
      valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      carry_q <= 1'b0;
      valid_q <= 1'b0;
    end else begin
      carry_q <= carry_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    digit_q <= digit_d;
  end

  assign carry_o = carry_q;
  assign valid_o = valid_q;
  assign digit_o = digit_q;

endmodule

// ----- design/radix_digit_string_converter.sv -----
// Top level: radix digit string converter with cell chain and sequencer.
//
// Usage: write the radix over the APB port (byte address 0; values in bits
// 5:0 below 2 read back as 2, above 36 as 36; reset value 10). Pulse start with
// value_i while busy is low to hand in one item.
// The value is fed MSB first, one bit per cycle, into a row of 64 digit
// cells. Each cell doubles its digit, adds the carry from its lower
// neighbor and reduces modulo the radix, then passes its carry up through
// a register. The conversion phase ends once the last input bit has
// reached the top cell.
// Then the digits shift up the chain one cell per cycle until all 64 are out; the
// top cell drives digit_char_o. Leading zeros are dropped: digit_strobe_o
// rises only from the first nonzero digit on, or for the lowest digit.
// last_digit_o flags the least significant digit.
// Results appear during the emit phase, one per cycle at most.
// The receiver cannot stall; each result is valid for one cycle only.
// Reset returns to idle with radix 10; no result is pending.
module radix_digit_string_converter (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [rdsc_pkg::AddrW-1:0]  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  input  logic                        start,
  output logic                        busy,
  input  logic [rdsc_pkg::ValueW-1:0] value_i,
  output logic                        digit_strobe_o,
  output logic [rdsc_pkg::CharW-1:0]  digit_char_o,
  output logic                        last_digit_o
);
  import rdsc_pkg::*;

  logic [RadixW-1:0] radix_q;
  logic [RadixW-1:0] wr_val;
  logic              cfg_wr;

  state_e            state_q, state_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [ValueW-1:0] shreg_q, shreg_d;
  logic              seen_q, seen_d;
  cell_ctrl_t        ctrl;
  logic              feed;

  logic [MaxDigits-1:0] carry;
  logic [MaxDigits-1:0] valid;
  logic [DigitW-1:0]    digit [MaxDigits];

  // Configuration: clamp on write
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == RegRadix);
  always_comb begin
    wr_val = pwdata[RadixW-1:0];
    if (wr_val < RadixMin) begin
      wr_val = RadixMin;
    end else if (wr_val > RadixMax) begin
      wr_val = RadixMax;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_q <= RadixReset;
    end else if (cfg_wr) begin
      radix_q <= wr_val;
    end
  end

  assign prdata = (paddr[2] == RegRadix) ? 32'(radix_q) : '0;

  // Sequencer
  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    shreg_d   = shreg_q;
    seen_d    = seen_q;
    ctrl      = '0;
    feed      = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (start) begin
          ctrl.clr = 1'b1;
          shreg_d  = value_i;
          cnt_d    = '0;
          seen_d   = 1'b0;
          state_d  = ST_CONV;
        end
      end
      ST_CONV: begin
        // feed one value bit per cycle while cnt_q is below ValueW
        feed = cnt_q < CntW'(ValueW);
        if (feed) begin
          shreg_d = {shreg_q[ValueW-2:0], 1'b0};
        end
        if (cnt_q == ConvLast) begin
          cnt_d   = '0;
          state_d = ST_EMIT;
        end else begin
          cnt_d = cnt_q + CntW'(1);
        end
      end
      ST_EMIT: begin
        ctrl.shift = 1'b1;
        if (digit[MaxDigits-1] != '0) begin
          seen_d = 1'b1;
        end
        if (cnt_q == EmitLast) begin
          state_d = ST_IDLE;
        end else begin
          cnt_d = cnt_q + CntW'(1);
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      seen_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      seen_q  <= seen_d;
    end
  end

  always_ff @(posedge clk_i) begin
    shreg_q <= shreg_d;
  end

  // Row of digit cells, least significant at index 0
  for (genvar k = 0; k < MaxDigits; k++) begin : g_cell
    rdsc_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (ctrl),
      .radix_i (radix_q),
      .carry_i ((k == 0) ? shreg_q[ValueW-1] : carry[(k == 0) ? 0 : k-1]),
      .valid_i ((k == 0) ? feed : valid[(k == 0) ? 0 : k-1]),
      .digit_i ((k == 0) ? DigitW'(0) : digit[(k == 0) ? 0 : k-1]),
      .carry_o (carry[k]),
      .valid_o (valid[k]),
      .digit_o (digit[k])
    );
  end

  // Output from the top cell, dropping leading zeros
  assign busy           = state_q != ST_IDLE;
  assign last_digit_o   = (state_q == ST_EMIT) && (cnt_q == EmitLast);
  assign digit_strobe_o = (state_q == ST_EMIT) &&
                          (seen_q || (digit[MaxDigits-1] != '0) || (cnt_q == EmitLast));
  assign digit_char_o   = digit_to_ascii(digit[MaxDigits-1]);

  a_strobe_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    digit_strobe_o |-> busy) else $error("digit strobe while idle");
  a_last_strobe : assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_digit_o |-> digit_strobe_o) else $error("last digit without strobe");
  a_start_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy) else $error("start not taken");
  a_radix_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (radix_q >= RadixMin) && (radix_q <= RadixMax)) else $error("radix out of range");

endmodule
